// ===== rtl/doss_pkg.sv =====
// ----------------------------------------------------------------------------
// doss_pkg: shared definitions for the daily on/off schedule switch
// Channel count, result limit, sequencer states and time helper functions.
// ----------------------------------------------------------------------------
package doss_pkg;

	localparam int CHANNELS = 8;
	localparam int MAX_RES  = 16;
	localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W    = $clog2(MAX_RES + 1);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [10:0]      minute_t;
	typedef logic [8:0]       day_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SET,
		ST_STEP,
		ST_FLUSH
	} doss_state_t;

	function automatic logic [4:0] mod24(input logic [7:0] x);
		logic [14:0] p;
		logic [3:0]  q;
		logic [7:0]  r;
		p = 15'(x) * 15'd85;
		q = p[14:11];
		r = x - 8'({4'b0, q} * 8'd24);
		if (r >= 8'd24) begin
			r = r - 8'd24;
		end
		return r[4:0];
	endfunction

	function automatic logic [5:0] mod60(input logic [7:0] x);
		logic [12:0] p;
		logic [2:0]  q;
		logic [7:0]  r;
		p = 13'(x) * 13'd17;
		q = p[12:10];
		r = x - 8'({5'b0, q} * 8'd60);
		if (r >= 8'd60) begin
			r = r - 8'd60;
		end
		return r[5:0];
	endfunction

	function automatic minute_t to_minutes(input logic [4:0] h, input logic [5:0] m);
		return minute_t'(11'(h) * 11'd60 + 11'(m));
	endfunction

	function automatic logic in_window(input minute_t now, input minute_t t_on,
			input minute_t t_off);
		logic r;
		if (t_on == t_off) begin
			r = 1'b0;
		end else if (t_on < t_off) begin
			r = (now >= t_on) && (now < t_off);
		end else begin
			r = (now >= t_on) || (now < t_off);
		end
		return r;
	endfunction

endpackage

// ===== rtl/doss_req_if.sv =====
// ----------------------------------------------------------------------------
// doss_req_if: request channel of the schedule switch
// Carries tick and set transactions with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface doss_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [2:0]  channel;
	logic        enable;
	logic [7:0]  on_hour;
	logic [7:0]  on_minute;
	logic [7:0]  off_hour;
	logic [7:0]  off_minute;
	logic [10:0] now_minute;
	logic [8:0]  day_of_year;
	logic        time_valid;

	modport source (
		output valid, req_type, channel, enable, on_hour, on_minute, off_hour,
			off_minute, now_minute, day_of_year, time_valid,
		input  ready
	);
	modport sink (
		input  valid, req_type, channel, enable, on_hour, on_minute, off_hour,
			off_minute, now_minute, day_of_year, time_valid,
		output ready
	);
endinterface

// ===== rtl/doss_res_if.sv =====
// ----------------------------------------------------------------------------
// doss_res_if: result channel of the schedule switch
// Carries switch command transactions with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface doss_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] out_channel;
	logic       switch_on;
	logic       last_of_run;

	modport source (
		output valid, out_channel, switch_on, last_of_run,
		input  ready
	);
	modport sink (
		input  valid, out_channel, switch_on, last_of_run,
		output ready
	);
endinterface

// ===== rtl/daily_on_off_schedule_switch.sv =====
// Sequencing: a tick with valid time walks all channels, then flushes: a disabled channel
// is skipped, an unsynced one is aligned to the current time, a synced one is checked at
// its on and then its off time. A tick without valid time changes nothing. A set writes its
// channel and, if enabled with valid time, emits its state. Output back-pressure stalls runs.
// Throughput: one request at a time; the sequencer walks the schedule table.
// Reset: all schedules disabled, never fired and not yet synced.
// ----------------------------------------------------------------------------
// daily_on_off_schedule_switch: daily on/off time switch
// Keeps per-channel on/off minutes and emits switch commands on ticks and sets.
// ----------------------------------------------------------------------------
module daily_on_off_schedule_switch
	import doss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	doss_req_if.sink    req,
	doss_res_if.source  res
);

	doss_state_t state_q, state_d;

	logic    en_q       [CHANNELS];
	minute_t on_t_q     [CHANNELS];
	minute_t off_t_q    [CHANNELS];
	day_t    on_day_q   [CHANNELS];
	day_t    off_day_q  [CHANNELS];
	logic    on_fired_q [CHANNELS];
	logic    off_fired_q[CHANNELS];
	logic    synced_q   [CHANNELS];

	logic       set_mode_q;
	logic       en_hold_q;
	logic       valid_hold_q;
	logic [7:0] on_h_q, on_m_q, off_h_q, off_m_q;
	minute_t    now_q;
	day_t       day_q;
	idx_t       idx_q;
	logic       phase_q;
	cnt_t       n_q;

	logic       pend_valid_q;
	logic [2:0] pend_ch_q;
	logic       pend_on_q;
	logic       out_valid_q;
	logic [2:0] out_ch_q;
	logic       out_on_q;
	logic       out_last_q;

	logic    accept;
	logic    ch_ok;
	logic    win, on_hit, off_hit;
	minute_t sel_on, sel_off;
	logic    emit_req, emit_on, wr_on, wr_off, wr_sync, adv_ch, to_phase1, last_step;
	logic    push, push_ok, step_go, flush_go, out_free;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign ch_ok     = (32'(req.channel) < CHANNELS);

	assign sel_on  = on_t_q[idx_q];
	assign sel_off = off_t_q[idx_q];
	assign win     = in_window(now_q, sel_on, sel_off);
	assign on_hit  = (now_q == sel_on) && !(on_fired_q[idx_q] && (on_day_q[idx_q] == day_q));
	assign off_hit = (now_q == sel_off) && !(off_fired_q[idx_q] && (off_day_q[idx_q] == day_q));

	assign out_free = !out_valid_q || res.ready;
	assign push     = emit_req && (n_q < cnt_t'(MAX_RES));
	assign push_ok  = !pend_valid_q || out_free;
	assign step_go  = (state_q == ST_STEP) && !(push && !push_ok);
	assign flush_go = !pend_valid_q || out_free;

	always_comb begin
		emit_req  = 1'b0;
		emit_on   = 1'b0;
		wr_on     = 1'b0;
		wr_off    = 1'b0;
		wr_sync   = 1'b0;
		adv_ch    = 1'b0;
		to_phase1 = 1'b0;
		last_step = 1'b0;
		if (state_q == ST_STEP) begin
			if (set_mode_q) begin
				emit_req  = 1'b1;
				emit_on   = win;
				wr_on     = win;
				wr_off    = !win;
				last_step = 1'b1;
			end else if (!phase_q) begin
				if (!en_q[idx_q]) begin
					adv_ch = 1'b1;
				end else if (!synced_q[idx_q]) begin
					emit_req = 1'b1;
					emit_on  = win;
					wr_on    = win;
					wr_off   = !win;
					wr_sync  = 1'b1;
					adv_ch   = 1'b1;
				end else begin
					emit_req  = on_hit;
					emit_on   = 1'b1;
					wr_on     = on_hit;
					to_phase1 = 1'b1;
				end
			end else begin
				emit_req = off_hit;
				emit_on  = 1'b0;
				wr_off   = off_hit;
				adv_ch   = 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.req_type) begin
						state_d = ch_ok ? ST_SET : ST_IDLE;
					end else begin
						state_d = req.time_valid ? ST_STEP : ST_IDLE;
					end
				end
			end
			ST_SET: begin
				state_d = (en_hold_q && valid_hold_q) ? ST_STEP : ST_IDLE;
			end
			ST_STEP: begin
				if (step_go && (last_step ||
						(adv_ch && (idx_q == idx_t'(CHANNELS - 1))))) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (flush_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			set_mode_q   <= req.req_type;
			en_hold_q    <= req.enable;
			valid_hold_q <= req.time_valid;
			on_h_q       <= req.on_hour;
			on_m_q       <= req.on_minute;
			off_h_q      <= req.off_hour;
			off_m_q      <= req.off_minute;
			now_q        <= req.now_minute;
			day_q        <= req.day_of_year;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			phase_q <= 1'b0;
			n_q     <= '0;
		end else if (accept) begin
			idx_q   <= req.req_type ? idx_t'(req.channel) : '0;
			phase_q <= 1'b0;
			n_q     <= '0;
		end else if (step_go) begin
			if (push) begin
				n_q <= n_q + cnt_t'(1);
			end
			if (adv_ch) begin
				idx_q   <= idx_q + idx_t'(1);
				phase_q <= 1'b0;
			end else if (to_phase1) begin
				phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				en_q[i]        <= 1'b0;
				on_t_q[i]      <= '0;
				off_t_q[i]     <= '0;
				on_fired_q[i]  <= 1'b0;
				off_fired_q[i] <= 1'b0;
				synced_q[i]    <= 1'b0;
			end
		end else if (state_q == ST_SET) begin
			en_q[idx_q]        <= en_hold_q;
			on_t_q[idx_q]      <= to_minutes(mod24(on_h_q), mod60(on_m_q));
			off_t_q[idx_q]     <= to_minutes(mod24(off_h_q), mod60(off_m_q));
			on_fired_q[idx_q]  <= 1'b0;
			off_fired_q[idx_q] <= 1'b0;
		end else if (step_go) begin
			if (wr_on) begin
				on_fired_q[idx_q] <= 1'b1;
			end
			if (wr_off) begin
				off_fired_q[idx_q] <= 1'b1;
			end
			if (wr_sync) begin
				synced_q[idx_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_go) begin
			if (wr_on) begin
				on_day_q[idx_q] <= day_q;
			end
			if (wr_off) begin
				off_day_q[idx_q] <= day_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (step_go && push) begin
				pend_valid_q <= 1'b1;
				if (pend_valid_q) begin
					out_valid_q <= 1'b1;
				end
			end else if ((state_q == ST_FLUSH) && pend_valid_q && out_free) begin
				pend_valid_q <= 1'b0;
				out_valid_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_go && push) begin
			pend_ch_q <= 3'(idx_q);
			pend_on_q <= emit_on;
			if (pend_valid_q) begin
				out_ch_q   <= pend_ch_q;
				out_on_q   <= pend_on_q;
				out_last_q <= 1'b0;
			end
		end else if ((state_q == ST_FLUSH) && pend_valid_q && out_free) begin
			out_ch_q   <= pend_ch_q;
			out_on_q   <= pend_on_q;
			out_last_q <= 1'b1;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.out_channel = out_ch_q;
	assign res.switch_on   = out_on_q;
	assign res.last_of_run = out_last_q;

endmodule

// ===== test/daily_on_off_schedule_switch_tb.sv =====
// ----------------------------------------------------------------------------
// daily_on_off_schedule_switch_tb: self-checking bench for the schedule switch
// Sends directed and random set and tick transactions with random idling on
// both channels. A scoreboard keeps its own copy of the schedule table,
// predicts every switch command and checks each result transaction in order.
// ----------------------------------------------------------------------------
module daily_on_off_schedule_switch_tb;
	import doss_pkg::*;

	typedef struct {
		bit          req_type;
		bit [2:0]    channel;
		bit          enable;
		bit [7:0]    on_hour;
		bit [7:0]    on_minute;
		bit [7:0]    off_hour;
		bit [7:0]    off_minute;
		bit [10:0]   now_minute;
		bit [8:0]    day_of_year;
		bit          time_valid;
	} request_t;

	typedef struct {
		bit [2:0] out_channel;
		bit       switch_on;
		bit       last_of_run;
	} command_t;

	localparam bit REQ_TICK = 1'b0;
	localparam bit REQ_SET  = 1'b1;

	class switch_scoreboard;
		bit       enabled [CHANNELS];
		minute_t  on_at [CHANNELS];
		minute_t  off_at [CHANNELS];
		day_t     on_day [CHANNELS];
		day_t     off_day [CHANNELS];
		bit       on_done [CHANNELS];
		bit       off_done [CHANNELS];
		bit       synced [CHANNELS];
		command_t batch[$];
		command_t expected_cmds[$];
		int       errors;

		function new();
			for (int c = 0; c < CHANNELS; c++) begin
				enabled[c] = 1'b0;
				on_at[c] = '0;
				off_at[c] = '0;
				on_day[c] = 9'h1FF;
				off_day[c] = 9'h1FF;
				on_done[c] = 1'b0;
				off_done[c] = 1'b0;
				synced[c] = 1'b0;
			end
			errors = 0;
		endfunction

		function bit window_open(minute_t now, minute_t t_on, minute_t t_off);
			if (t_on == t_off) begin
				return 1'b0;
			end
			if (t_on < t_off) begin
				return now >= t_on && now < t_off;
			end
			return now >= t_on || now < t_off;
		endfunction

		function void add_command(int c, bit on);
			command_t cmd;
			if (batch.size() < MAX_RES) begin
				cmd.out_channel = c[2:0];
				cmd.switch_on = on;
				cmd.last_of_run = 1'b0;
				batch.push_back(cmd);
			end
		endfunction

		function void align_to_now(int c, minute_t now, day_t day);
			bit lit;
			lit = window_open(now, on_at[c], off_at[c]);
			if (lit) begin
				on_day[c] = day;
				on_done[c] = 1'b1;
			end else begin
				off_day[c] = day;
				off_done[c] = 1'b1;
			end
			add_command(c, lit);
		endfunction

		function void note_request(request_t r);
			int c;
			batch.delete();
			if (r.req_type == REQ_SET) begin
				c = int'(r.channel);
				if (c >= CHANNELS) begin
					return;
				end
				enabled[c] = r.enable;
				on_at[c] = minute_t'((int'(r.on_hour) % 24) * 60 + int'(r.on_minute) % 60);
				off_at[c] = minute_t'((int'(r.off_hour) % 24) * 60 + int'(r.off_minute) % 60);
				on_day[c] = 9'h1FF;
				off_day[c] = 9'h1FF;
				on_done[c] = 1'b0;
				off_done[c] = 1'b0;
				if (r.enable && r.time_valid) begin
					align_to_now(c, r.now_minute, r.day_of_year);
				end
			end else if (r.time_valid) begin
				for (c = 0; c < CHANNELS; c++) begin
					if (!enabled[c]) begin
						continue;
					end
					if (!synced[c]) begin
						synced[c] = 1'b1;
						align_to_now(c, r.now_minute, r.day_of_year);
						continue;
					end
					if (r.now_minute == on_at[c] &&
							!(on_done[c] && on_day[c] == r.day_of_year)) begin
						on_day[c] = r.day_of_year;
						on_done[c] = 1'b1;
						add_command(c, 1'b1);
					end
					if (r.now_minute == off_at[c] &&
							!(off_done[c] && off_day[c] == r.day_of_year)) begin
						off_day[c] = r.day_of_year;
						off_done[c] = 1'b1;
						add_command(c, 1'b0);
					end
				end
			end
			if (batch.size() > 0) begin
				batch[batch.size() - 1].last_of_run = 1'b1;
			end
			foreach (batch[k]) begin
				expected_cmds.push_back(batch[k]);
			end
		endfunction

		function void check_result(bit [2:0] out_channel, bit switch_on, bit last_of_run);
			command_t want;
			if (expected_cmds.size() == 0) begin
				$error("unexpected result: out_channel %0d switch_on %0d last_of_run %0d",
					out_channel, switch_on, last_of_run);
				errors++;
				return;
			end
			want = expected_cmds.pop_front();
			if (out_channel != want.out_channel) begin
				$error("out_channel: expected %0d, actual %0d", want.out_channel, out_channel);
				errors++;
			end
			if (switch_on != want.switch_on) begin
				$error("switch_on: expected %0d, actual %0d", want.switch_on, switch_on);
				errors++;
			end
			if (last_of_run != want.last_of_run) begin
				$error("last_of_run: expected %0d, actual %0d", want.last_of_run, last_of_run);
				errors++;
			end
		endfunction

		function int pending();
			return expected_cmds.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   quiet = 1'b0;
	bit   hold_output = 1'b0;

	switch_scoreboard sb;

	doss_req_if req_bus ();
	doss_res_if res_bus ();

	daily_on_off_schedule_switch dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.res    (res_bus)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic request_t make_set(bit [2:0] ch, bit en, bit [7:0] oh, bit [7:0] om,
			bit [7:0] fh, bit [7:0] fm, bit [10:0] now, bit [8:0] day, bit valid);
		request_t r;
		r.req_type = REQ_SET;
		r.channel = ch;
		r.enable = en;
		r.on_hour = oh;
		r.on_minute = om;
		r.off_hour = fh;
		r.off_minute = fm;
		r.now_minute = now;
		r.day_of_year = day;
		r.time_valid = valid;
		return r;
	endfunction

	function automatic request_t make_tick(bit [10:0] now, bit [8:0] day, bit valid);
		request_t r;
		r = make_set(3'($urandom), 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), now, day, valid);
		r.req_type = REQ_TICK;
		return r;
	endfunction

	task automatic send_request(input request_t r);
		req_bus.valid <= 1'b1;
		req_bus.req_type <= r.req_type;
		req_bus.channel <= r.channel;
		req_bus.enable <= r.enable;
		req_bus.on_hour <= r.on_hour;
		req_bus.on_minute <= r.on_minute;
		req_bus.off_hour <= r.off_hour;
		req_bus.off_minute <= r.off_minute;
		req_bus.now_minute <= r.now_minute;
		req_bus.day_of_year <= r.day_of_year;
		req_bus.time_valid <= r.time_valid;
		do @(posedge clk); while (!req_bus.ready);
		sb.note_request(r);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	initial begin
		bit hold_done;
		hold_done = 1'b0;
		res_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_output && !hold_done) begin
				res_bus.ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				res_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				res_bus.ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_bus.valid && res_bus.ready) begin
			sb.check_result(res_bus.out_channel, res_bus.switch_on, res_bus.last_of_run);
		end
	end

	initial begin
		#1_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		request_t r;
		int       c;
		day_t     today;
		minute_t  prev_now;
		sb = new();
		arst_n <= 1'b0;
		req_bus.valid <= 1'b0;
		req_bus.req_type <= REQ_TICK;
		req_bus.channel <= '0;
		req_bus.enable <= 1'b0;
		req_bus.on_hour <= '0;
		req_bus.on_minute <= '0;
		req_bus.off_hour <= '0;
		req_bus.off_minute <= '0;
		req_bus.now_minute <= '0;
		req_bus.day_of_year <= '0;
		req_bus.time_valid <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(make_tick(11'd600, 9'd0, 1'b1));
		send_request(make_set(3'd0, 1'b1, 8'hFF, 8'hFF, 8'd0, 8'd0, 11'd1000, 9'd0, 1'b1));
		send_request(make_set(3'd7, 1'b1, 8'd8, 8'd0, 8'd17, 8'd30, 11'd0, 9'd0, 1'b0));
		send_request(make_set(3'd3, 1'b0, 8'd1, 8'd2, 8'd3, 8'd4, 11'd5, 9'd0, 1'b1));
		send_request(make_set(3'd5, 1'b1, 8'd36, 8'd120, 8'd12, 8'd0, 11'd720, 9'd365, 1'b1));
		send_request(make_tick(11'd480, 9'd10, 1'b0));
		send_request(make_tick(11'd480, 9'd10, 1'b1));
		send_request(make_tick(11'd480, 9'd10, 1'b1));
		send_request(make_tick(11'd720, 9'd10, 1'b1));
		send_request(make_tick(11'd1050, 9'd10, 1'b1));
		send_request(make_tick(11'h7FF, 9'h1FF, 1'b1));
		send_request(make_tick(11'd480, 9'h1FF, 1'b1));
		for (c = 0; c < CHANNELS; c++) begin
			send_request(make_set(3'(c), 1'b1, 8'd240, 8'd180, 8'd0, 8'd0, 11'h7FF, 9'd0, 1'b0));
		end
		send_request(make_tick(11'd100, 9'd1, 1'b1));
		send_request(make_tick(11'd0, 9'd2, 1'b1));

		today = 9'd3;
		prev_now = '0;
		for (int i = 0; i < 350; i++) begin
			if (i == 80) begin
				hold_output = 1'b1;
			end
			if (i == 290) begin
				quiet = 1'b1;
			end
			if ($urandom_range(0, 9) == 0) begin
				today = $urandom_range(0, 1) ? today + 9'd1 : 9'($urandom_range(0, 511));
			end
			if ($urandom_range(0, 9) < 3) begin
				r = make_set(3'($urandom), $urandom_range(0, 3) != 0, 8'($urandom_range(0, 23)),
					8'($urandom_range(0, 59)), 8'($urandom_range(0, 23)),
					8'($urandom_range(0, 59)), 11'($urandom_range(0, 1439)), today,
					$urandom_range(0, 7) != 0);
				if ($urandom_range(0, 1) == 0) begin
					r.on_hour = 8'($urandom);
					r.on_minute = 8'($urandom);
					r.off_hour = 8'($urandom);
					r.off_minute = 8'($urandom);
				end
				if ($urandom_range(0, 9) == 0) begin
					r.off_hour = r.on_hour;
					r.off_minute = r.on_minute;
				end
				if ($urandom_range(0, 9) == 0) begin
					r.now_minute = 11'($urandom_range(1440, 2047));
				end
			end else begin
				c = $urandom_range(0, CHANNELS - 1);
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5: r = make_tick(sb.on_at[c], today, 1'b1);
					6, 7, 8, 9, 10, 11: r = make_tick(sb.off_at[c], today, 1'b1);
					12, 13: r = make_tick(prev_now, today, 1'b1);
					14: r = make_tick(11'($urandom_range(1440, 2047)), today, 1'b1);
					default: r = make_tick(11'($urandom_range(0, 1439)), today, 1'b1);
				endcase
				if ($urandom_range(0, 9) == 0) begin
					r.time_valid = 1'b0;
				end
				prev_now = r.now_minute;
			end
			send_request(r);
		end
		req_bus.valid <= 1'b0;

		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== daily_on_off_schedule_switch.f =====
rtl/doss_pkg.sv
rtl/doss_req_if.sv
rtl/doss_res_if.sv
rtl/daily_on_off_schedule_switch.sv
test/daily_on_off_schedule_switch_tb.sv
